// File: sv/int8_gemm_tile_2x2_scaled_top_assert.svh
// Assertion macros for the int8 GEMM tile RTL.
// Include by bare file name inside a module body; no other dependencies.
`ifndef INT8_GEMM_TILE_2X2_SCALED_TOP_ASSERT_SVH
`define INT8_GEMM_TILE_2X2_SCALED_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IGT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IGT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/igt_pkg.sv
// Shared constants and types for the int8 2x2 GEMM tile.
// No dependencies; imported by every module of the block.
package igt_pkg;

    localparam int LANES         = 8;
    localparam int BYTE_W        = 8;
    localparam int ROW_W         = LANES * BYTE_W;
    localparam int SCALE_W       = 32;
    localparam int WSCALE_W      = 2 * SCALE_W;
    localparam int BIAS_W        = 32;
    localparam int OUT_W         = 32;
    localparam int NUM_RES       = 4;
    localparam int RES_IDX_W     = $clog2(NUM_RES);
    localparam int DOT_W         = 2 * BYTE_W + $clog2(LANES);
    localparam int ACC_WIDTH_DEF = 32;
    localparam int CHUNK_W       = 32;

    localparam int S_TDATA_W = 4 * ROW_W + 2 * SCALE_W + 2 * BIAS_W;
    localparam int M_TDATA_W = NUM_RES * OUT_W;

    // Register map: one 32-bit register, word index taken from paddr[2].
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int REG_IDX_LSB   = 2;
    localparam logic REG_DEQ_GAIN = 1'b0;
    localparam logic [SCALE_W-1:0] DEQ_GAIN_RST = 32'h0100_0000;

    // Q.48 product -> Q16.16: drop 32 fraction bits, magnitude clamped to 2^40.
    localparam int FRAC_DROP = 32;
    localparam int R_W       = 41;
    localparam logic [R_W-1:0] R_CLAMP = {1'b1, {(R_W-1){1'b0}}};
    localparam int V_W       = R_W + 1;
    localparam int T_W       = V_W + 1;
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic        [WSCALE_W-1:0] scale_a;
        logic        [WSCALE_W-1:0] scale_b;
        logic signed [BIAS_W-1:0]   bias_a;
        logic signed [BIAS_W-1:0]   bias_b;
    } col_param_t;

endpackage

// File: sv/igt_dot8.sv
// Eight signed byte lanes and an adder tree forming one registered dot product.
// Depends on igt_pkg.
module igt_dot8 (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [igt_pkg::ROW_W-1:0]        row,
    input  logic [igt_pkg::ROW_W-1:0]        col,
    output logic signed [igt_pkg::DOT_W-1:0] dot_o
);
    import igt_pkg::*;

    logic signed [2*BYTE_W-1:0] prod [LANES];
    logic signed [DOT_W-1:0]    lvl1 [LANES/2];
    logic signed [DOT_W-1:0]    lvl2 [LANES/4];
    logic signed [DOT_W-1:0]    sum;
    logic signed [DOT_W-1:0]    dot_reg;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            prod[i] = $signed(row[i*BYTE_W +: BYTE_W]) * $signed(col[i*BYTE_W +: BYTE_W]);
        end
        for (int i = 0; i < LANES / 2; i++) begin
            lvl1[i] = DOT_W'(prod[2*i]) + DOT_W'(prod[2*i+1]);
        end
        for (int i = 0; i < LANES / 4; i++) begin
            lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
        end
        sum = lvl2[0] + lvl2[1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dot_reg <= sum;
        end
    end

    assign dot_o = dot_reg;

endmodule

// File: sv/igt_finalize.sv
// Tile finalize sequencer: scales, rounds, adds bias and saturates four sums.
// Depends on igt_pkg and int8_gemm_tile_2x2_scaled_top_assert.svh.
module igt_finalize #(
    parameter int ACC_WIDTH = igt_pkg::ACC_WIDTH_DEF
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                start_i,
    input  logic [igt_pkg::NUM_RES-1:0][ACC_WIDTH-1:0]          acc_i,
    input  igt_pkg::col_param_t                                 col_i,
    output logic                                                idle_o,
    output logic                                                m_tvalid,
    input  logic                                                m_tready,
    // out_ra_ca, out_ra_cb, out_rb_ca, out_rb_cb from bit 0 up
    output logic [igt_pkg::M_TDATA_W-1:0]                       m_tdata
);
    import igt_pkg::*;

    `include "int8_gemm_tile_2x2_scaled_top_assert.svh"

    localparam int MAG_CHUNKS = (ACC_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int S_CHUNKS   = WSCALE_W / CHUNK_W;
    localparam int MAG_PAD_W  = MAG_CHUNKS * CHUNK_W;
    localparam int NPP        = MAG_CHUNKS * S_CHUNKS;
    localparam int PPC_W      = $clog2(NPP);
    localparam int SH_W       = $clog2(MAG_CHUNKS + S_CHUNKS - 1);
    localparam int PROD_W     = MAG_PAD_W + WSCALE_W;
    localparam logic [PROD_W-1:0] ROUND_INIT = PROD_W'(1) << (FRAC_DROP - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DRAIN,
        ST_ROUND,
        ST_BIAS,
        ST_OUT
    } state_t;

    state_t                              state_reg;
    logic [RES_IDX_W-1:0]                res_idx_reg;
    logic [PPC_W-1:0]                    pp_cnt_reg;
    logic                                pp_vld_reg;
    logic [NUM_RES-1:0][ACC_WIDTH-1:0]   acc_reg;
    col_param_t                          col_reg;
    logic [ACC_WIDTH-1:0]                mag_reg;
    logic                                neg_reg;
    logic [2*CHUNK_W-1:0]                pp_reg;
    logic [SH_W-1:0]                     pp_sh_reg;
    logic [PROD_W-1:0]                   prod_reg;
    logic [R_W-1:0]                      r_reg;
    logic [NUM_RES-1:0][OUT_W-1:0]       res_reg;

    logic [ACC_WIDTH-1:0]                acc_sel;
    logic [WSCALE_W-1:0]                 s_sel;
    logic signed [BIAS_W-1:0]            bias_sel;
    logic [MAG_PAD_W-1:0]                mag_pad;
    logic [PPC_W-1:0]                    a_idx;
    logic                                b_idx;
    logic [CHUNK_W-1:0]                  a_chunk;
    logic [CHUNK_W-1:0]                  b_chunk;
    logic [2*CHUNK_W-1:0]                pp_prod;
    logic [SH_W-1:0]                     pp_sh;
    logic [PROD_W-1:0]                   pp_shifted;
    logic                                hi_any;
    logic [R_W-1:0]                      r_val;
    logic signed [V_W-1:0]               v_val;
    logic signed [T_W-1:0]               t_val;
    logic                                t_fits;
    logic [OUT_W-1:0]                    sat_val;

    always_comb begin
        acc_sel  = acc_reg[res_idx_reg];
        // Result index is row*2 + column, so its low bit picks the column.
        s_sel    = res_idx_reg[0] ? col_reg.scale_b : col_reg.scale_a;
        bias_sel = res_idx_reg[0] ? col_reg.bias_b : col_reg.bias_a;

        // One 32x32 partial product per cycle: magnitude chunk by scale chunk.
        mag_pad  = MAG_PAD_W'(mag_reg);
        a_idx    = pp_cnt_reg >> 1;
        b_idx    = pp_cnt_reg[0];
        a_chunk  = CHUNK_W'(mag_pad >> (CHUNK_W * a_idx));
        b_chunk  = CHUNK_W'(s_sel >> (CHUNK_W * b_idx));
        pp_prod  = a_chunk * b_chunk;
        pp_sh    = SH_W'(a_idx) + SH_W'(b_idx);
        pp_shifted = PROD_W'(pp_reg) << (CHUNK_W * pp_sh_reg);

        // The rounding half was preloaded into the product, so only the shift
        // and the clamp remain here.
        hi_any = |prod_reg[PROD_W-1:FRAC_DROP+R_W-1];
        r_val  = hi_any ? R_CLAMP : R_W'(prod_reg[FRAC_DROP +: R_W-1]);

        v_val   = neg_reg ? -$signed(V_W'(r_reg)) : $signed(V_W'(r_reg));
        t_val   = T_W'(v_val) + T_W'(bias_sel);
        t_fits  = (&t_val[T_W-1:OUT_W-1]) || !(|t_val[T_W-1:OUT_W-1]);
        sat_val = t_fits ? t_val[OUT_W-1:0] : (t_val[T_W-1] ? OUT_MIN : OUT_MAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            res_idx_reg <= '0;
            pp_cnt_reg  <= '0;
            pp_vld_reg  <= 1'b0;
        end else begin
            pp_vld_reg <= (state_reg == ST_MUL);
            case (state_reg)
                ST_IDLE: begin
                    res_idx_reg <= '0;
                    if (start_i) begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    pp_cnt_reg <= '0;
                    state_reg  <= ST_MUL;
                end
                ST_MUL: begin
                    pp_cnt_reg <= pp_cnt_reg + 1'b1;
                    if (pp_cnt_reg == PPC_W'(NPP - 1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    state_reg <= ST_BIAS;
                end
                ST_BIAS: begin
                    if (res_idx_reg == RES_IDX_W'(NUM_RES - 1)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        res_idx_reg <= res_idx_reg + 1'b1;
                        state_reg   <= ST_LOAD;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        res_idx_reg <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start_i) begin
            acc_reg <= acc_i;
            col_reg <= col_i;
        end
        if (state_reg == ST_LOAD) begin
            neg_reg  <= acc_sel[ACC_WIDTH-1];
            mag_reg  <= acc_sel[ACC_WIDTH-1] ? -acc_sel : acc_sel;
            prod_reg <= ROUND_INIT;
        end else if (pp_vld_reg) begin
            prod_reg <= prod_reg + pp_shifted;
        end
        pp_reg    <= pp_prod;
        pp_sh_reg <= pp_sh;
        if (state_reg == ST_ROUND) begin
            r_reg <= r_val;
        end
        if (state_reg == ST_BIAS) begin
            res_reg[res_idx_reg] <= sat_val;
        end
    end

    assign idle_o   = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = res_reg;

    `IGT_ASSERT_IMP(a_start_when_idle, aclk, aresetn, start_i, state_reg == ST_IDLE,
        "finalize started while busy")
    `IGT_ASSERT_IMP(a_idle_index_clear, aclk, aresetn, state_reg == ST_IDLE,
        res_idx_reg == '0, "result index not cleared in idle")
    `IGT_ASSERT_NXT(a_last_pp_drains, aclk, aresetn,
        state_reg == ST_MUL && pp_cnt_reg == PPC_W'(NPP - 1),
        state_reg == ST_DRAIN && pp_vld_reg, "last partial product not drained")
    `IGT_ASSERT_IMP(a_round_clamped, aclk, aresetn, state_reg == ST_BIAS,
        r_reg <= R_CLAMP, "rounded magnitude above clamp")

endmodule

// File: sv/int8_gemm_tile_2x2_scaled_top.sv
// Path: a final K block beat is registered in the input stage, then the finalize unit scales its four
// sums in turn on the shared 32x32 finalize multiplier and holds the tile result for the output.
// Throughput: one K block beat per cycle while no final beat is held; a final beat waits
// in the input stage until the previous tile result has been taken.
// Reset: aresetn is synchronous, active low; it clears the accumulators and control state
// and sets the activation scale to 1.0.
module int8_gemm_tile_2x2_scaled_top #(
    parameter int ACC_WIDTH = igt_pkg::ACC_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // act_row_a, act_row_b, wgt_col_a, wgt_col_b, scale_col_a, scale_col_b,
    // bias_col_a, bias_col_b from bit 0 up
    input  logic [igt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_ra_ca, out_ra_cb, out_rb_ca, out_rb_cb from bit 0 up
    output logic [igt_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [igt_pkg::PADDR_W-1:0]     paddr,
    input  logic [igt_pkg::PDATA_W-1:0]     pwdata,
    output logic [igt_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import igt_pkg::*;

    logic [ROW_W-1:0]                  rows [2];
    logic [ROW_W-1:0]                  cols [2];
    logic [SCALE_W-1:0]                scale_col_a;
    logic [SCALE_W-1:0]                scale_col_b;
    logic signed [BIAS_W-1:0]          bias_col_a;
    logic signed [BIAS_W-1:0]          bias_col_b;

    logic [SCALE_W-1:0]                deq_gain_reg;
    logic                              reg_sel;
    logic                              s_accept;
    logic                              v1_reg;
    logic                              last1_reg;
    col_param_t                        col1_reg;
    logic                              move1;
    logic                              fin_idle;
    logic signed [DOT_W-1:0]           dot [NUM_RES];
    logic [NUM_RES-1:0][ACC_WIDTH-1:0] acc_reg;
    logic [NUM_RES-1:0][ACC_WIDTH-1:0] acc_next;

    assign rows[0]     = s_tdata[0*ROW_W +: ROW_W];
    assign rows[1]     = s_tdata[1*ROW_W +: ROW_W];
    assign cols[0]     = s_tdata[2*ROW_W +: ROW_W];
    assign cols[1]     = s_tdata[3*ROW_W +: ROW_W];
    assign scale_col_a = s_tdata[4*ROW_W +: SCALE_W];
    assign scale_col_b = s_tdata[4*ROW_W + SCALE_W +: SCALE_W];
    assign bias_col_a  = s_tdata[4*ROW_W + 2*SCALE_W +: BIAS_W];
    assign bias_col_b  = s_tdata[4*ROW_W + 2*SCALE_W + BIAS_W +: BIAS_W];

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:REG_IDX_LSB] == REG_DEQ_GAIN);
    assign prdata  = reg_sel ? deq_gain_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deq_gain_reg <= DEQ_GAIN_RST;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            deq_gain_reg <= pwdata;
        end
    end

    // Input stage: a final beat holds here until the finalize unit is free.
    assign move1    = v1_reg && !(last1_reg && !fin_idle);
    assign s_tready = !v1_reg || move1;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_accept) begin
            v1_reg <= 1'b1;
        end else if (move1) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            last1_reg        <= s_tlast;
            col1_reg.scale_a <= WSCALE_W'(deq_gain_reg) * WSCALE_W'(scale_col_a);
            col1_reg.scale_b <= WSCALE_W'(deq_gain_reg) * WSCALE_W'(scale_col_b);
            col1_reg.bias_a  <= bias_col_a;
            col1_reg.bias_b  <= bias_col_b;
        end
    end

    for (genvar k = 0; k < NUM_RES; k++) begin : g_lane
        igt_dot8 u_dot (
            .aclk  (aclk),
            .en    (s_accept),
            .row   (rows[k / 2]),
            .col   (cols[k % 2]),
            .dot_o (dot[k])
        );
    end

    always_comb begin
        for (int k = 0; k < NUM_RES; k++) begin
            acc_next[k] = acc_reg[k] + ACC_WIDTH'(dot[k]);
        end
    end

    // The final block's sums go to the finalize unit and the tile restarts at zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (move1) begin
            if (last1_reg) begin
                acc_reg <= '0;
            end else begin
                acc_reg <= acc_next;
            end
        end
    end

    igt_finalize #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_fin (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start_i  (move1 && last1_reg),
        .acc_i    (acc_next),
        .col_i    (col1_reg),
        .idle_o   (fin_idle),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the int8 2x2 GEMM tile with per-channel scaling.
// It needs igt_pkg and int8_gemm_tile_2x2_scaled_top; it checks the four Q16.16 tile
// results of every final K block beat against a predictor that runs inside the testbench.
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int LONG_BLOCKS  = 256;
    localparam int RAND_PHASE   = 290;

    localparam logic [igt_pkg::PADDR_W-1:0] ADDR_DEQ_GAIN =
        igt_pkg::PADDR_W'(igt_pkg::REG_DEQ_GAIN) << igt_pkg::REG_IDX_LSB;
    // Word address with no register behind it; writes there must be dropped.
    localparam logic [igt_pkg::PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

    localparam logic [63:0] LANES_NEG_MAX = {8{8'h80}};
    localparam logic [63:0] LANES_POS_MAX = {8{8'h7f}};
    localparam logic [31:0] SCALE_ONE     = 32'h0100_0000;
    localparam logic [31:0] SCALE_MAX     = 32'hffff_ffff;
    localparam logic [31:0] BIAS_MAX      = 32'h7fff_ffff;
    localparam logic [31:0] BIAS_MIN      = 32'h8000_0000;

    typedef enum int {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_SPARSE,
        RDY_MOSTLY
    } rdy_mode_t;

    typedef struct {
        logic [63:0]        row_a;
        logic [63:0]        row_b;
        logic [63:0]        col_a;
        logic [63:0]        col_b;
        logic [31:0]        scl_a;
        logic [31:0]        scl_b;
        logic signed [31:0] bias_a;
        logic signed [31:0] bias_b;
        logic               last;
    } kblock_t;

    // Index 0 is row a / column a, then ra_cb, rb_ca, rb_cb, as on m_tdata.
    typedef logic [igt_pkg::NUM_RES-1:0][igt_pkg::OUT_W-1:0] tile_res_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [igt_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [igt_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [igt_pkg::PADDR_W-1:0]     paddr = '0;
    logic [igt_pkg::PDATA_W-1:0]     pwdata = '0;
    logic [igt_pkg::PDATA_W-1:0]     prdata;
    logic                            pready;

    int8_gemm_tile_2x2_scaled_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    kblock_t   kblock_q[$];
    tile_res_t tile_q[$];

    // Predictor state: the four tile accumulators and the activation scale.
    logic [31:0] tile_acc[igt_pkg::NUM_RES];
    logic [31:0] deq_gain_q = SCALE_ONE;

    string res_name[igt_pkg::NUM_RES] = '{"ra_ca", "ra_cb", "rb_ca", "rb_cb"};

    int  err_cnt = 0;
    int  beats_in = 0;
    int  tiles_checked = 0;
    int  reg_writes = 0;
    int  cycle_cnt = 0;
    logic in_beat_taken = 1'b0;
    logic hold_req = 1'b0;

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int dot8(input logic [63:0] row, input logic [63:0] col);
        int  sum;
        byte ra;
        byte cb;
        sum = 0;
        for (int i = 0; i < igt_pkg::LANES; i++) begin
            ra = row[8*i +: 8];
            cb = col[8*i +: 8];
            sum += int'(ra) * int'(cb);
        end
        return sum;
    endfunction

    // acc * activation scale * wscale, rounded half away from zero to Q16.16,
    // magnitude clamped to 2^40, then bias added and saturated to 32 bits.
    function automatic logic [31:0] scale_to_q16(input logic [31:0] acc,
                                                 input logic [31:0] wscale,
                                                 input logic signed [31:0] bias);
        logic [127:0] comb_scale;
        logic [127:0] mag;
        logic [127:0] rnd;
        logic         neg;
        longint       r;
        longint       sum;
        comb_scale = deq_gain_q;
        comb_scale = comb_scale * wscale;
        neg = acc[31];
        mag = neg ? (128'h1_0000_0000 - acc) : acc;
        rnd = (mag * comb_scale + (128'd1 << 31)) >> 32;
        if (rnd >= (128'd1 << 40)) begin
            rnd = 128'd1 << 40;
        end
        r = longint'(rnd[40:0]);
        sum = (neg ? -r : r) + longint'(bias);
        if (sum > longint'(32'sh7fff_ffff)) begin
            sum = longint'(32'sh7fff_ffff);
        end else if (sum < -longint'(64'd2147483648)) begin
            sum = -longint'(64'd2147483648);
        end
        return sum[31:0];
    endfunction

    task automatic accumulate_kblock(input logic [igt_pkg::S_TDATA_W-1:0] data,
                                     input logic last);
        kblock_t   b;
        tile_res_t res;
        {b.bias_b, b.bias_a, b.scl_b, b.scl_a, b.col_b, b.col_a, b.row_b, b.row_a} = data;
        tile_acc[0] = tile_acc[0] + dot8(b.row_a, b.col_a);
        tile_acc[1] = tile_acc[1] + dot8(b.row_a, b.col_b);
        tile_acc[2] = tile_acc[2] + dot8(b.row_b, b.col_a);
        tile_acc[3] = tile_acc[3] + dot8(b.row_b, b.col_b);
        if (last) begin
            res[0] = scale_to_q16(tile_acc[0], b.scl_a, b.bias_a);
            res[1] = scale_to_q16(tile_acc[1], b.scl_b, b.bias_b);
            res[2] = scale_to_q16(tile_acc[2], b.scl_a, b.bias_a);
            res[3] = scale_to_q16(tile_acc[3], b.scl_b, b.bias_b);
            tile_q.push_back(res);
            for (int i = 0; i < igt_pkg::NUM_RES; i++) begin
                tile_acc[i] = '0;
            end
        end
    endtask

    task automatic check_tile(input logic [igt_pkg::M_TDATA_W-1:0] data);
        tile_res_t want;
        tile_res_t got;
        got = data;
        if (tile_q.size() == 0) begin
            $display("%0t: ERROR: tile result beat with none expected, actual %h", $time, data);
            err_cnt++;
        end else begin
            want = tile_q.pop_front();
            for (int i = 0; i < igt_pkg::NUM_RES; i++) begin
                if (got[i] !== want[i]) begin
                    $display("%0t: ERROR: %s expected %h actual %h",
                             $time, res_name[i], want[i], got[i]);
                    err_cnt++;
                end
            end
        end
        tiles_checked++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: ERROR: timeout after %0d cycles", $time, CYCLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else if (!aresetn) begin
            in_beat_taken <= 1'b0;
            for (int i = 0; i < igt_pkg::NUM_RES; i++) begin
                tile_acc[i] = '0;
            end
        end else begin
            in_beat_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                accumulate_kblock(s_tdata, s_tlast);
                beats_in++;
            end
            if (m_tvalid && m_tready) begin
                check_tile(m_tdata);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input driver: bursts of beats with random gaps, changes at the falling edge.
    // ------------------------------------------------------------------
    int      burst_left = 0;
    int      gap_left = 0;
    kblock_t drv_blk;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else if (!s_tvalid || in_beat_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (kblock_q.size() > 0) begin
                drv_blk = kblock_q.pop_front();
                s_tdata <= {drv_blk.bias_b, drv_blk.bias_a, drv_blk.scl_b, drv_blk.scl_a,
                            drv_blk.col_b, drv_blk.col_a, drv_blk.row_b, drv_blk.row_a};
                s_tlast  <= drv_blk.last;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: its own stall pattern plus one long hold on request.
    // ------------------------------------------------------------------
    rdy_mode_t rdy_mode = RDY_ALWAYS;
    int        rdy_left = 0;
    int        hold_left = 0;
    logic      hold_ack = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else begin
            if (rdy_left == 0) begin
                rdy_mode = rdy_mode_t'($urandom_range(0, 3));
                rdy_left = $urandom_range(8, 80);
            end else begin
                rdy_left--;
            end
            case (rdy_mode)
                RDY_ALWAYS: m_tready <= 1'b1;
                RDY_HALF:   m_tready <= 1'($urandom_range(0, 1));
                RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:    m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_kblock(input logic [63:0] row_a, input logic [63:0] row_b,
                               input logic [63:0] col_a, input logic [63:0] col_b,
                               input logic [31:0] scl_a, input logic [31:0] scl_b,
                               input logic [31:0] bias_a, input logic [31:0] bias_b,
                               input logic last);
        kblock_t b;
        b.row_a = row_a;
        b.row_b = row_b;
        b.col_a = col_a;
        b.col_b = col_b;
        b.scl_a = scl_a;
        b.scl_b = scl_b;
        b.bias_a = bias_a;
        b.bias_b = bias_b;
        b.last = last;
        kblock_q.push_back(b);
    endtask

    function automatic logic [63:0] rand_lanes();
        logic [63:0] w;
        case ($urandom_range(0, 9))
            0: w = LANES_NEG_MAX;
            1: w = LANES_POS_MAX;
            2: w = '0;
            3, 4: begin
                for (int i = 0; i < 8; i++) begin
                    w[8*i +: 8] = 8'($signed($urandom_range(0, 8)) - 4);
                end
            end
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return SCALE_MAX;
            2: return SCALE_ONE;
            3, 4: return $urandom_range(0, 32'h0100_0000);
            5, 6, 7: return $urandom_range(0, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_bias();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return BIAS_MAX;
            2: return BIAS_MIN;
            default: return $urandom;
        endcase
    endfunction

    // Complete tiles of random depth; a few all-zero tiles mimic fully padded edges.
    task automatic push_random_tiles(input int n_beats);
        int          cnt;
        int          depth;
        logic [31:0] sa;
        logic [31:0] sb;
        logic [31:0] ba;
        logic [31:0] bb;
        bit          pad;
        cnt = 0;
        while (cnt < n_beats) begin
            depth = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 8);
            pad = ($urandom_range(0, 19) == 0);
            for (int k = 0; k < depth; k++) begin
                sa = rand_scale();
                sb = rand_scale();
                ba = rand_bias();
                bb = rand_bias();
                if (pad) begin
                    push_kblock('0, '0, '0, '0, sa, sb, ba, bb, k == depth - 1);
                end else begin
                    push_kblock(rand_lanes(), rand_lanes(), rand_lanes(), rand_lanes(),
                                sa, sb, ba, bb, k == depth - 1);
                end
            end
            cnt += depth;
        end
    endtask

    task automatic wait_idle();
        while (kblock_q.size() != 0 || s_tvalid || tile_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [igt_pkg::PADDR_W-1:0] addr,
                             input logic [igt_pkg::PDATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (addr == ADDR_DEQ_GAIN) begin
            deq_gain_q = data;
        end
        reg_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read_check(input logic [igt_pkg::PADDR_W-1:0] addr,
                                  input logic [igt_pkg::PDATA_W-1:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want) begin
            $display("%0t: ERROR: register read at %h expected %h actual %h",
                     $time, addr, want, prdata);
            err_cnt++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    logic [31:0] phase_scale[6];

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Activation scale at its reset value of 1.0.
        reg_read_check(ADDR_DEQ_GAIN, SCALE_ONE);
        push_kblock('0, '0, '0, '0, '0, '0, '0, '0, 1'b1);
        push_kblock(LANES_POS_MAX, LANES_POS_MAX, LANES_NEG_MAX, LANES_NEG_MAX,
                    SCALE_ONE, SCALE_ONE, BIAS_MAX, BIAS_MIN, 1'b1);
        push_kblock(LANES_NEG_MAX, LANES_NEG_MAX, LANES_NEG_MAX, LANES_NEG_MAX,
                    SCALE_MAX, SCALE_MAX, '0, '0, 1'b1);
        // Products of exactly one half LSB: +1 and -1 must round away from zero.
        push_kblock(64'h1, 64'h3, 64'h1, 64'hff, 32'd128, 32'd128, '0, '0, 1'b1);
        push_kblock(64'h7f, 64'h80, 64'hff, 64'h1, 32'd127, 32'd129, '0, '0, 1'b1);
        // Multi-block tile with the second row and column absent.
        for (int k = 0; k < 4; k++) begin
            push_kblock(rand_lanes(), '0, rand_lanes(), '0, 32'h0001_0000, 32'h0003_0000,
                        32'h0001_8000, 32'hffff_0000, k == 3);
        end
        push_kblock({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, $urandom, $urandom, $urandom, $urandom, 1'b1);
        wait_idle();

        // Largest scales: the scaled product is clamped before the bias is added.
        reg_write(ADDR_DEQ_GAIN, SCALE_MAX);
        reg_read_check(ADDR_DEQ_GAIN, SCALE_MAX);
        push_kblock(LANES_NEG_MAX, LANES_POS_MAX, LANES_NEG_MAX, LANES_NEG_MAX,
                    SCALE_MAX, SCALE_MAX, BIAS_MAX, BIAS_MAX, 1'b1);
        push_kblock(LANES_NEG_MAX, LANES_POS_MAX, LANES_POS_MAX, LANES_NEG_MAX,
                    SCALE_MAX, 32'h1, BIAS_MIN, BIAS_MAX, 1'b1);
        push_kblock(64'h1, 64'hff, 64'h1, 64'h1, 32'h1, 32'h2, '0, '0, 1'b1);
        wait_idle();

        // Zero activation scale: every result is just the bias.
        reg_write(ADDR_DEQ_GAIN, '0);
        push_kblock(LANES_NEG_MAX, LANES_POS_MAX, {$urandom, $urandom}, LANES_NEG_MAX,
                    SCALE_MAX, SCALE_MAX, $urandom, $urandom, 1'b1);
        wait_idle();
        // A write to an unmapped word must leave the activation scale alone.
        reg_write(ADDR_UNMAPPED, 32'h5a5a_a5a5);
        reg_read_check(ADDR_DEQ_GAIN, '0);

        // One long tile that builds accumulator sums far beyond the result range.
        reg_write(ADDR_DEQ_GAIN, SCALE_ONE);
        for (int k = 0; k < LONG_BLOCKS; k++) begin
            push_kblock(LANES_NEG_MAX, LANES_NEG_MAX, LANES_NEG_MAX, LANES_NEG_MAX,
                        32'd1, SCALE_ONE, 32'd7, BIAS_MIN, k == LONG_BLOCKS - 1);
        end
        wait_idle();

        // Random tiles under several activation scales.
        phase_scale[0] = SCALE_ONE;
        phase_scale[1] = $urandom;
        phase_scale[2] = SCALE_MAX;
        phase_scale[3] = $urandom_range(0, 32'h0400_0000);
        phase_scale[4] = 32'h0000_0100;
        phase_scale[5] = 32'h0000_0000;
        for (int p = 0; p < 6; p++) begin
            reg_write(ADDR_DEQ_GAIN, phase_scale[p]);
            push_random_tiles(RAND_PHASE);
            if (p == 1) begin
                // Result side blocks for a while so the tile engine backs up its input.
                hold_req = ~hold_req;
            end
            wait_idle();
        end

        $display("Run covered %0d K block beats, %0d checked tile results and %0d register writes,",
                 beats_in, tiles_checked, reg_writes);
        $display("including half-LSB rounding, clamped products, long tiles and saturation.");
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
